### design/hsc_pkg.sv
// ----------------------------------------------------------------------------
// hsc_pkg: shared types and tables for the Hamming SEC codec
// Width codes, opcodes, status codes, per-mode masks and the fixed codeword
// position of every data bit.
// ----------------------------------------------------------------------------
package hsc_pkg;

  localparam int unsigned DATA_W  = 64;
  localparam int unsigned CHECK_W = 7;
  localparam int unsigned SEL_W   = 3;

  typedef logic [DATA_W-1:0]  data_t;
  typedef logic [CHECK_W-1:0] check_t;

  typedef enum logic [SEL_W-1:0] {
    WSEL_8  = 3'd0,
    WSEL_12 = 3'd1,
    WSEL_16 = 3'd2,
    WSEL_24 = 3'd3,
    WSEL_32 = 3'd4,
    WSEL_48 = 3'd5,
    WSEL_64 = 3'd6
  } wsel_t;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_CLEAN     = 2'd0,
    ST_CORRECTED = 2'd1,
    ST_RANGE     = 2'd2
  } status_t;

  // codeword position of each data bit; independent of the width mode
  typedef check_t pos_tab_t [DATA_W];

  function automatic pos_tab_t build_pos();
    pos_tab_t t;
    int       k;
    k = 0;
    for (int p = 3; p < 128; p++) begin
      if (((p & (p - 1)) != 0) && (k < DATA_W)) begin
        t[k] = CHECK_W'(p);
        k++;
      end
    end
    return t;
  endfunction

  localparam pos_tab_t DATA_POS = build_pos();

  // unsupported code saturates to the 64-bit mode
  function automatic data_t mode_dmask(logic [SEL_W-1:0] sel);
    data_t m;
    case (wsel_t'(sel))
      WSEL_8:  m = data_t'({8{1'b1}});
      WSEL_12: m = data_t'({12{1'b1}});
      WSEL_16: m = data_t'({16{1'b1}});
      WSEL_24: m = data_t'({24{1'b1}});
      WSEL_32: m = data_t'({32{1'b1}});
      WSEL_48: m = data_t'({48{1'b1}});
      default: m = '1;
    endcase
    return m;
  endfunction

  function automatic check_t mode_cmask(logic [SEL_W-1:0] sel);
    check_t m;
    case (wsel_t'(sel))
      WSEL_8:  m = 7'h0f;
      WSEL_12: m = 7'h1f;
      WSEL_16: m = 7'h1f;
      WSEL_24: m = 7'h1f;
      WSEL_32: m = 7'h3f;
      WSEL_48: m = 7'h3f;
      default: m = 7'h7f;
    endcase
    return m;
  endfunction

  // codeword length n = data bits + check bits
  function automatic check_t mode_len(logic [SEL_W-1:0] sel);
    check_t n;
    case (wsel_t'(sel))
      WSEL_8:  n = 7'd12;
      WSEL_12: n = 7'd17;
      WSEL_16: n = 7'd21;
      WSEL_24: n = 7'd29;
      WSEL_32: n = 7'd38;
      WSEL_48: n = 7'd54;
      default: n = 7'd71;
    endcase
    return n;
  endfunction

endpackage

### design/hamming_sec_codec_selectable_width.sv
// ----------------------------------------------------------------------------
// hamming_sec_codec_selectable_width: pipelined Hamming SEC encoder/decoder
// Encodes data into check bits or decodes and corrects one bit, for data
// widths of 8 to 64 bits chosen by a configuration register.
// ----------------------------------------------------------------------------
//  Channel | Handshake             | Payload
//  --------+-----------------------+-------------------------------------------
//  in      | in_valid / in_ready   | in_opcode, in_data_in, in_check_in
//  out     | out_valid / out_ready | out_data_out, out_check_out, out_syndrome,
//          |                       | out_status
//  cfg     | cfg_wr_en             | cfg_wr_data (width select)
//
//  Three register stages: mask, parity tree, syndrome and correction.
//  A request passes the mask, parity and output registers in order before it
//  shows on out_valid; one request per cycle is sustained, limited by
//  nothing but the output handshake.
//  A stall at the output holds every stage; empty stages still fill.
//  Synchronous reset clears stage valids and selects the 8-bit mode.
// ----------------------------------------------------------------------------
module hamming_sec_codec_selectable_width
  import hsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [SEL_W-1:0]   cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_opcode,
  input  logic [DATA_W-1:0]  in_data_in,
  input  logic [CHECK_W-1:0] in_check_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [DATA_W-1:0]  out_data_out,
  output logic [CHECK_W-1:0] out_check_out,
  output logic [CHECK_W-1:0] out_syndrome,
  output logic [1:0]         out_status
);

  logic [SEL_W-1:0] wsel_r;

  logic en1, en2, en3;

  // stage 1: masked inputs
  logic    s1_valid_r;
  opcode_t s1_op_r;
  data_t   s1_data_r;
  check_t  s1_chk_r, s1_cmask_r, s1_len_r;

  // stage 2: parity
  logic    s2_valid_r;
  opcode_t s2_op_r;
  data_t   s2_data_r;
  check_t  s2_chk_r, s2_acc_r, s2_len_r;
  check_t  acc_nxt;

  // stage 3: output register
  logic    out_valid_r;
  data_t   out_data_r, data_nxt;
  check_t  out_check_r, check_nxt;
  check_t  out_synd_r, synd_nxt;
  status_t out_status_r, status_nxt;

  assign en3      = !out_valid_r || out_ready;
  assign en2      = !s2_valid_r || en3;
  assign en1      = !s1_valid_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsel_r      <= SEL_W'(WSEL_8);
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        wsel_r <= cfg_wr_data;
      end
      if (en1) begin
        s1_valid_r <= in_valid;
      end
      if (en2) begin
        s2_valid_r <= s1_valid_r;
      end
      if (en3) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_op_r    <= opcode_t'(in_opcode);
      s1_data_r  <= in_data_in & mode_dmask(wsel_r);
      s1_chk_r   <= in_check_in & mode_cmask(wsel_r);
      s1_cmask_r <= mode_cmask(wsel_r);
      s1_len_r   <= mode_len(wsel_r);
    end
  end

  // XOR of the positions of all set data bits
  always_comb begin
    acc_nxt = '0;
    for (int k = 0; k < DATA_W; k++) begin
      if (s1_data_r[k]) begin
        acc_nxt = acc_nxt ^ DATA_POS[k];
      end
    end
    acc_nxt = acc_nxt & s1_cmask_r;
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_op_r   <= s1_op_r;
      s2_data_r <= s1_data_r;
      s2_chk_r  <= s1_chk_r;
      s2_acc_r  <= acc_nxt;
      s2_len_r  <= s1_len_r;
    end
  end

  // stage 3: syndrome, range check, single-bit flip
  always_comb begin
    data_nxt   = s2_data_r;
    check_nxt  = s2_acc_r;
    synd_nxt   = '0;
    status_nxt = ST_CLEAN;
    if (s2_op_r == OP_DECODE) begin
      check_nxt = s2_chk_r;
      synd_nxt  = s2_acc_r ^ s2_chk_r;
      if (synd_nxt != '0) begin
        if (synd_nxt > s2_len_r) begin
          status_nxt = ST_RANGE;
        end else begin
          status_nxt = ST_CORRECTED;
          if ((synd_nxt & (synd_nxt - 1'b1)) == '0) begin
            check_nxt = s2_chk_r ^ synd_nxt;
          end else begin
            // positions above n never match here, so only live bits flip
            for (int k = 0; k < DATA_W; k++) begin
              if (DATA_POS[k] == synd_nxt) begin
                data_nxt[k] = ~s2_data_r[k];
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      out_data_r   <= data_nxt;
      out_check_r  <= check_nxt;
      out_synd_r   <= synd_nxt;
      out_status_r <= status_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data_out  = out_data_r;
  assign out_check_out = out_check_r;
  assign out_syndrome  = out_synd_r;
  assign out_status    = out_status_r;

endmodule

### design/hsc_checker.sv
// ----------------------------------------------------------------------------
// hsc_checker: port-level checks for the Hamming SEC codec
// Watches the result channel and the consistency of syndrome and status.
// ----------------------------------------------------------------------------
module hsc_checker
  import hsc_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [DATA_W-1:0]  out_data_out,
  input logic [CHECK_W-1:0] out_check_out,
  input logic [CHECK_W-1:0] out_syndrome,
  input logic [1:0]         out_status
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_out)
      && $stable(out_check_out) && $stable(out_syndrome) && $stable(out_status))
    else $error("result changed while stalled");

  // zero syndrome exactly when clean
  a_clean_synd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_syndrome == '0) == (out_status == ST_CLEAN)))
    else $error("syndrome and clean status disagree");

  // out-of-range only past the shortest codeword
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_RANGE) |-> (out_syndrome > 7'd12))
    else $error("range flag on a syndrome inside every codeword");

  // a correction never names a position past the longest codeword
  a_corr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_CORRECTED) |-> (out_syndrome <= 7'd71))
    else $error("correction past the longest codeword");

endmodule

bind hamming_sec_codec_selectable_width hsc_checker u_hsc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_data_out  (out_data_out),
  .out_check_out (out_check_out),
  .out_syndrome  (out_syndrome),
  .out_status    (out_status)
);
